// File: rtl/partition_fit_allocator_core_macros.svh
// Assertion macros used by the partition allocator checker.
`ifndef PARTITION_FIT_ALLOCATOR_CORE_MACROS_SVH
`define PARTITION_FIT_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, reset masked.
`define PFA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masked.
`define PFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pfa_pkg.sv
// Shared types and constants of the partition fit allocator.
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

  localparam int SIZE_W  = 16;
  localparam int SLOT_W  = 4;
  localparam int CHOSEN_W = 4;
  localparam int POL_W   = 2;
  localparam int COUNT_W = 5;
  localparam int CFG_W   = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

  // Fit rule codes; the unused code behaves as first fit.
  typedef enum logic [POL_W-1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2
  } pol_e;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_REQUEST = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIT_POLICY = 1'b0,
    CFG_PART_COUNT = 1'b1
  } cfg_idx_e;

  // Search record handed from cell to cell; the chosen index travels beside it.
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [SIZE_W-1:0] sel_val;
  } scan_rec_t;

endpackage

`default_nettype wire

// File: rtl/pfa_cell.sv
// One partition cell: holds a free size and updates the passing search record.
`timescale 1ns / 1ps
`default_nettype none

module pfa_cell #(
  parameter int IDX_W    = 4,
  parameter int CNT_W    = 5,
  parameter int CELL_IDX = 0
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  pfa_pkg::scan_rec_t     rec_i,
  input  wire  [IDX_W-1:0]             idx_i,
  input  wire  [pfa_pkg::SIZE_W-1:0]   need_i,
  input  wire  [pfa_pkg::POL_W-1:0]    policy_i,
  input  wire  [CNT_W-1:0]             lim_i,
  input  wire                          wr_en_i,
  input  wire  [IDX_W-1:0]             wr_idx_i,
  input  wire  [pfa_pkg::SIZE_W-1:0]   wr_val_i,
  output pfa_pkg::scan_rec_t           rec_o,
  output logic [IDX_W-1:0]             idx_o
);
  import pfa_pkg::*;

  logic [SIZE_W-1:0] free_q;
  logic              valid_q;
  logic              found_q;
  logic [SIZE_W-1:0] sel_val_q;
  logic [IDX_W-1:0]  idx_q;

  logic in_use;
  logic fits;
  logic better;
  logic take;

  // Decide whether this partition replaces the candidate so far
  assign in_use = CNT_W'(CELL_IDX) < lim_i;
  assign fits   = in_use && (free_q >= need_i);
  assign better = ((policy_i == POL_BEST)  && (free_q < rec_i.sel_val)) ||
                  ((policy_i == POL_WORST) && (free_q > rec_i.sel_val));
  assign take   = rec_i.valid && fits && (!rec_i.found || better);

  // Hold the stored free size; load and write-back share one port
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_idx_i == IDX_W'(CELL_IDX))) begin
      free_q <= wr_val_i;
    end
  end

  // Advance the record valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= rec_i.valid;
    end
  end

  // Advance the record payload
  always_ff @(posedge clk_i) begin
    found_q   <= rec_i.found | take;
    sel_val_q <= take ? free_q : rec_i.sel_val;
    idx_q     <= take ? IDX_W'(CELL_IDX) : idx_i;
  end

  assign rec_o = '{valid: valid_q, found: found_q, sel_val: sel_val_q};
  assign idx_o = idx_q;

endmodule

`default_nettype wire

// File: rtl/partition_fit_allocator_core.sv
// Top level of the partition fit allocator: control, registers and cell chain.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries opcode, partition slot and size.
//   A load writes the free size of one partition and gives no result; the
//   block stays idle and ready for the next item.
//   A request sends a search record down a chain of MAX_PARTS cells, one cell
//   per cycle, each cell holding one partition. The record leaving the chain
//   is caught in the result registers; once the output register is free, the
//   result enters it and any chosen partition is written back at the same time.
//   The input stalls from an accepted request until its result enters the
//   output register, so no new item is taken while a request is in progress.
//   Output channel (out_valid_o / out_stall_i) holds the result until taken;
//   a stalled result blocks only the next result, not the accept of new items.
//   Configuration writes (fit policy, partition count) take effect at once and
//   must be made while the block is idle; the block does not enforce this.
//   Reset clears control state, sets first fit and a count of 16; partition
//   sizes are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module partition_fit_allocator_core #(
  parameter int MAX_PARTS = 16
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [pfa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [pfa_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire                            opcode_i,
  input  wire  [pfa_pkg::SLOT_W-1:0]     partition_slot_i,
  input  wire  [pfa_pkg::SIZE_W-1:0]     size_value_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic                           granted_o,
  output logic [pfa_pkg::CHOSEN_W-1:0]   chosen_partition_o,
  output logic [pfa_pkg::SIZE_W-1:0]     remaining_free_o
);
  import pfa_pkg::*;

  localparam int IDX_W = $clog2(MAX_PARTS);
  localparam int CNT_W = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;
  localparam int EXT_W = IDX_W + SLOT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_e;

  state_e              state_q;
  logic [POL_W-1:0]    policy_q;
  logic [COUNT_W-1:0]  count_q;
  logic [SIZE_W-1:0]   need_q;
  logic                launch_q;
  logic                res_found_q;
  logic [IDX_W-1:0]    res_idx_q;
  logic [SIZE_W-1:0]   res_left_q;
  logic                out_valid_q;
  logic                granted_q;
  logic [IDX_W-1:0]    chosen_q;
  logic [SIZE_W-1:0]   left_q;

  logic                in_acc;
  logic                out_free;
  logic                load_ok;
  logic [EXT_W-1:0]    slot_ext;
  logic [EXT_W-1:0]    chosen_ext;
  logic [CNT_W-1:0]    count_ext;
  logic [CNT_W-1:0]    lim;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_idx;
  logic [SIZE_W-1:0]   wr_val;

  scan_rec_t           rec   [MAX_PARTS+1];
  logic [IDX_W-1:0]    idx_c [MAX_PARTS+1];

  // Handshake
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Slot range check and scan limit
  assign slot_ext  = {{IDX_W{1'b0}}, partition_slot_i};
  assign load_ok   = slot_ext < EXT_W'(MAX_PARTS);
  assign count_ext = CNT_W'(count_q);
  assign lim       = (count_ext > CNT_W'(MAX_PARTS)) ? CNT_W'(MAX_PARTS) : count_ext;

  // Shared write port: loads while idle, write-back as the result leaves
  always_comb begin
    wr_en  = 1'b0;
    wr_idx = slot_ext[IDX_W-1:0];
    wr_val = size_value_i;
    if (state_q == ST_RESULT) begin
      wr_en  = out_free && res_found_q;
      wr_idx = res_idx_q;
      wr_val = res_left_q;
    end else if (in_acc && (opcode_i == OP_LOAD)) begin
      wr_en  = load_ok;
    end
  end

  // Feed the head of the chain
  assign rec[0]   = '{valid: launch_q, found: 1'b0, sel_val: '0};
  assign idx_c[0] = '0;

  for (genvar k = 0; k < MAX_PARTS; k++) begin : g_cell
    pfa_cell #(
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W),
      .CELL_IDX (k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .rec_i    (rec[k]),
      .idx_i    (idx_c[k]),
      .need_i   (need_q),
      .policy_i (policy_q),
      .lim_i    (lim),
      .wr_en_i  (wr_en),
      .wr_idx_i (wr_idx),
      .wr_val_i (wr_val),
      .rec_o    (rec[k+1]),
      .idx_o    (idx_c[k+1])
    );
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_FIRST;
      count_q  <= COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FIT_POLICY: policy_q <= cfg_wdata_i[POL_W-1:0];
        CFG_PART_COUNT: count_q  <= cfg_wdata_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Request size, held for the whole scan
  always_ff @(posedge clk_i) begin
    if (in_acc && (opcode_i == OP_REQUEST)) begin
      need_q <= size_value_i;
    end
  end

  // Capture the record leaving the chain
  always_ff @(posedge clk_i) begin
    if (rec[MAX_PARTS].valid) begin
      res_found_q <= rec[MAX_PARTS].found;
      res_idx_q   <= idx_c[MAX_PARTS];
      res_left_q  <= rec[MAX_PARTS].sel_val - need_q;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      launch_q <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && (opcode_i == OP_REQUEST)) begin
            launch_q <= 1'b1;
            state_q  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rec[MAX_PARTS].valid) begin
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Result payload; zeroed when nothing fits
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_RESULT) && out_free) begin
      granted_q <= res_found_q;
      chosen_q  <= res_found_q ? res_idx_q : '0;
      left_q    <= res_found_q ? res_left_q : '0;
    end
  end

  assign chosen_ext         = {{SLOT_W{1'b0}}, chosen_q};
  assign out_valid_o        = out_valid_q;
  assign granted_o          = granted_q;
  assign chosen_partition_o = chosen_ext[CHOSEN_W-1:0];
  assign remaining_free_o   = left_q;

endmodule

`default_nettype wire

// File: rtl/pfa_checker.sv
// Port-level checks for the partition fit allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "partition_fit_allocator_core_macros.svh"

module pfa_checker (
  input wire                            clk_i,
  input wire                            rst_ni,
  input wire                            in_valid_i,
  input wire                            in_stall_i,
  input wire                            opcode_i,
  input wire                            out_valid_i,
  input wire                            out_stall_i,
  input wire                            granted_i,
  input wire [pfa_pkg::CHOSEN_W-1:0]    chosen_partition_i,
  input wire [pfa_pkg::SIZE_W-1:0]      remaining_free_i
);
  import pfa_pkg::*;

  logic req_acc;
  logic load_acc;

  assign req_acc  = in_valid_i && !in_stall_i && (opcode_i == OP_REQUEST);
  assign load_acc = in_valid_i && !in_stall_i && (opcode_i == OP_LOAD);

  // Hold a stalled result
  `PFA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i,
    out_valid_i && $stable(granted_i) && $stable(chosen_partition_i) &&
    $stable(remaining_free_i), "stalled result changed")

  // A refused request reports zero index and size
  `PFA_ASSERT_IMPL(a_no_grant_zero, clk_i, rst_ni, out_valid_i && !granted_i,
    (chosen_partition_i == '0) && (remaining_free_i == '0),
    "refused request with nonzero payload")

  // One request in flight: the input closes right after a request
  `PFA_ASSERT_NEXT(a_req_blocks, clk_i, rst_ni, req_acc, in_stall_i,
    "input open during a search")

  // A load never produces a result
  `PFA_ASSERT_NEXT(a_load_silent, clk_i, rst_ni, load_acc && !out_valid_i, !out_valid_i,
    "result after a load")

endmodule

bind partition_fit_allocator_core pfa_checker u_pfa_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_i         (in_stall_o),
  .opcode_i           (opcode_i),
  .out_valid_i        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .granted_i          (granted_o),
  .chosen_partition_i (chosen_partition_o),
  .remaining_free_i   (remaining_free_o)
);

`default_nettype wire
